>>> hdl/usart_rb_pkg.sv
// Package for the USART register block: word types, command and status codes,
// register offsets and bit positions. No dependencies.
package usart_rb_pkg;

  localparam int WINDOW_BYTES = 1024;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RX    = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RX_ACCEPTED = 2'd0,
    RX_REFUSED  = 2'd1,
    RX_DROPPED  = 2'd2,
    RX_UNUSED   = 2'd3
  } rx_status_t;

  localparam logic [9:0] OFS_CR1  = 10'h000;
  localparam logic [9:0] OFS_CR2  = 10'h004;
  localparam logic [9:0] OFS_CR3  = 10'h008;
  localparam logic [9:0] OFS_BRR  = 10'h00C;
  localparam logic [9:0] OFS_GTPR = 10'h010;
  localparam logic [9:0] OFS_RTOR = 10'h014;
  localparam logic [9:0] OFS_RQR  = 10'h018;
  localparam logic [9:0] OFS_ISR  = 10'h01C;
  localparam logic [9:0] OFS_ICR  = 10'h020;
  localparam logic [9:0] OFS_RDR  = 10'h024;
  localparam logic [9:0] OFS_TDR  = 10'h028;

  localparam int CR1_UE_BIT     = 0;
  localparam int CR1_RE_BIT     = 2;
  localparam int CR1_RXNEIE_BIT = 5;
  localparam int ISR_RXNE_BIT   = 5;
  localparam int ISR_TC_BIT     = 6;
  localparam int ISR_TXE_BIT    = 7;

  localparam logic [31:0] ISR_RESET_VALUE = 32'h0000_00C0;
  localparam logic [31:0] ISR_REPLACE_MAX = 32'h0000_03FF;
  localparam logic [31:0] TDR_LIMIT       = 32'h0000_0100;

  typedef struct packed {
    cmd_t        cmd;
    logic [9:0]  reg_offset;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;
  } usart_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    rx_status_t  rx_status;
  } usart_out_t;

endpackage

>>> hdl/usart_register_block_top.sv
// USART register block top level: register file, receive path and result register.
// Depends on usart_rb_pkg.
//
// Usage:
//   in_valid/in_ready/in_data carry one word per command: a bus read, a bus
//   write, or a byte arriving from the serial line (cmd selects which).
//   out_valid/out_ready/out_data carry one result word for every command:
//   read data, interrupt level, a transmitted byte and the receive status.
//   The register file is updated at the accepting edge and the result sits
//   in the output register from the next cycle on.
//   Throughput is one word per cycle while the receiver takes every result;
//   in_ready stays high while the output register is empty or being taken
//   in the same cycle.
//   When the receiver stalls, the result is held and in_ready drops until
//   the output register frees, so no word is lost.
//   Reset (rst_n low, synchronous) clears the register-file registers to zero,
//   loads the status register with TXE and TC set instead, lowers the interrupt
//   and empties the output register.
module usart_register_block_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  usart_rb_pkg::usart_in_t  in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output usart_rb_pkg::usart_out_t out_data
);

  logic [31:0] cr1_r, cr1_nxt;
  logic [31:0] cr2_r, cr2_nxt;
  logic [31:0] cr3_r, cr3_nxt;
  logic [31:0] brr_r, brr_nxt;
  logic [31:0] gtpr_r, gtpr_nxt;
  logic [31:0] rtor_r, rtor_nxt;
  logic [31:0] rqr_r, rqr_nxt;
  logic [31:0] isr_r, isr_nxt;
  logic [31:0] icr_r, icr_nxt;
  logic [7:0]  rdr_r, rdr_nxt;
  logic        irq_r, irq_nxt;

  logic                     out_valid_r, out_valid_nxt;
  usart_rb_pkg::usart_out_t out_data_r, out_data_nxt;

  logic accept;
  logic known;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign known = (32'(in_data.reg_offset) < 32'(usart_rb_pkg::WINDOW_BYTES));

  always_comb begin
    logic [31:0] isr_tmp;
    logic [31:0] rdata;
    logic        irq_tmp;
    logic        tx_v;
    logic [7:0]  tx_b;
    usart_rb_pkg::rx_status_t rx_st;

    cr1_nxt  = cr1_r;
    cr2_nxt  = cr2_r;
    cr3_nxt  = cr3_r;
    brr_nxt  = brr_r;
    gtpr_nxt = gtpr_r;
    rtor_nxt = rtor_r;
    rqr_nxt  = rqr_r;
    icr_nxt  = icr_r;
    rdr_nxt  = rdr_r;
    isr_tmp  = isr_r;
    irq_tmp  = irq_r;
    rdata    = '0;
    tx_v     = 1'b0;
    tx_b     = '0;
    rx_st    = usart_rb_pkg::RX_ACCEPTED;

    case (in_data.cmd)
      usart_rb_pkg::CMD_READ: begin
        if (known) begin
          unique case (in_data.reg_offset)
            usart_rb_pkg::OFS_CR1:  rdata = cr1_r;
            usart_rb_pkg::OFS_CR2:  rdata = cr2_r;
            usart_rb_pkg::OFS_CR3:  rdata = cr3_r;
            usart_rb_pkg::OFS_BRR:  rdata = brr_r;
            usart_rb_pkg::OFS_GTPR: rdata = gtpr_r;
            usart_rb_pkg::OFS_RTOR: rdata = rtor_r;
            usart_rb_pkg::OFS_RQR:  rdata = rqr_r;
            usart_rb_pkg::OFS_ISR:  rdata = isr_r;
            usart_rb_pkg::OFS_ICR:  rdata = icr_r;
            usart_rb_pkg::OFS_RDR: begin
              // data read consumes the byte
              rdata = {24'd0, rdr_r};
              isr_tmp[usart_rb_pkg::ISR_RXNE_BIT] = 1'b0;
              irq_tmp = 1'b0;
            end
            default: rdata = '0;
          endcase
        end
      end
      usart_rb_pkg::CMD_WRITE: begin
        if (known) begin
          unique case (in_data.reg_offset)
            usart_rb_pkg::OFS_CR1: begin
              cr1_nxt = in_data.write_data;
              if (in_data.write_data[usart_rb_pkg::CR1_RXNEIE_BIT] &&
                  isr_r[usart_rb_pkg::ISR_RXNE_BIT]) begin
                irq_tmp = 1'b1;
              end
            end
            usart_rb_pkg::OFS_CR2:  cr2_nxt  = in_data.write_data;
            usart_rb_pkg::OFS_CR3:  cr3_nxt  = in_data.write_data;
            usart_rb_pkg::OFS_BRR:  brr_nxt  = in_data.write_data;
            usart_rb_pkg::OFS_GTPR: gtpr_nxt = in_data.write_data;
            usart_rb_pkg::OFS_RTOR: rtor_nxt = in_data.write_data;
            usart_rb_pkg::OFS_RQR:  rqr_nxt  = in_data.write_data;
            usart_rb_pkg::OFS_ISR: begin
              // small values replace (TXE kept), larger ones mask
              if (in_data.write_data <= usart_rb_pkg::ISR_REPLACE_MAX) begin
                isr_tmp = in_data.write_data;
                isr_tmp[usart_rb_pkg::ISR_TXE_BIT] = 1'b1;
              end else begin
                isr_tmp = isr_r & in_data.write_data;
              end
              if (!isr_tmp[usart_rb_pkg::ISR_RXNE_BIT]) begin
                irq_tmp = 1'b0;
              end
            end
            usart_rb_pkg::OFS_ICR:  icr_nxt  = in_data.write_data;
            usart_rb_pkg::OFS_TDR: begin
              if (in_data.write_data < usart_rb_pkg::TDR_LIMIT) begin
                tx_v = 1'b1;
                tx_b = in_data.write_data[7:0];
                isr_tmp[usart_rb_pkg::ISR_TC_BIT] = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      usart_rb_pkg::CMD_RX: begin
        if (isr_r[usart_rb_pkg::ISR_RXNE_BIT]) begin
          rx_st = usart_rb_pkg::RX_REFUSED;
        end else if (!(cr1_r[usart_rb_pkg::CR1_UE_BIT] && cr1_r[usart_rb_pkg::CR1_RE_BIT])) begin
          rx_st = usart_rb_pkg::RX_DROPPED;
        end else begin
          rdr_nxt = in_data.rx_byte;
          isr_tmp[usart_rb_pkg::ISR_RXNE_BIT] = 1'b1;
          if (cr1_r[usart_rb_pkg::CR1_RXNEIE_BIT]) begin
            irq_tmp = 1'b1;
          end
        end
      end
      default: ;
    endcase

    isr_nxt = isr_tmp;
    irq_nxt = irq_tmp;

    out_data_nxt.read_data = rdata;
    out_data_nxt.irq_level = irq_tmp;
    out_data_nxt.tx_valid  = tx_v;
    out_data_nxt.tx_byte   = tx_b;
    out_data_nxt.rx_status = rx_st;

    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr1_r       <= '0;
      cr2_r       <= '0;
      cr3_r       <= '0;
      brr_r       <= '0;
      gtpr_r      <= '0;
      rtor_r      <= '0;
      rqr_r       <= '0;
      isr_r       <= usart_rb_pkg::ISR_RESET_VALUE;
      icr_r       <= '0;
      rdr_r       <= '0;
      irq_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        cr1_r  <= cr1_nxt;
        cr2_r  <= cr2_nxt;
        cr3_r  <= cr3_nxt;
        brr_r  <= brr_nxt;
        gtpr_r <= gtpr_nxt;
        rtor_r <= rtor_nxt;
        rqr_r  <= rqr_nxt;
        isr_r  <= isr_nxt;
        icr_r  <= icr_nxt;
        rdr_r  <= rdr_nxt;
        irq_r  <= irq_nxt;
      end
    end
  end

  // result word needs no reset; hold it while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

>>> hdl/usart_rb_chk.sv
// Port checker for the USART register block, bound to the top level.
// Depends on usart_rb_pkg.
module usart_rb_chk (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input usart_rb_pkg::usart_in_t  in_data,
  input logic                     out_valid,
  input logic                     out_ready,
  input usart_rb_pkg::usart_out_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending straight after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // a word is a read, a transmit or a receive, never two at once
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.tx_valid |->
      out_data.read_data == 32'd0 && out_data.rx_status == usart_rb_pkg::RX_ACCEPTED)
    else $error("transmit mixed with read or receive status");

  a_tx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.tx_valid |-> out_data.tx_byte == 8'd0)
    else $error("transmit byte set without transmit");

endmodule

bind usart_register_block_top usart_rb_chk u_usart_rb_chk (.*);

>>> tb/tb_usart_register_block_top.sv
// Self-checking testbench for usart_register_block_top: directed and random register
// accesses and line bytes, with a built-in register-file predictor. Depends on usart_rb_pkg.
module tb_usart_register_block_top;

  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_WORDS = 1650;

  typedef struct packed {
    usart_rb_pkg::usart_in_t word;
    logic                    hold;
  } pending_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  usart_rb_pkg::usart_in_t  in_data = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  usart_rb_pkg::usart_out_t out_data;

  pending_t                 pend_q[$];
  usart_rb_pkg::usart_out_t expected_q[$];
  int                       fail_count = 0;

  // predicted register file
  logic [31:0] cr1_m = '0, cr2_m = '0, cr3_m = '0, brr_m = '0, gtpr_m = '0;
  logic [31:0] rtor_m = '0, rqr_m = '0, icr_m = '0;
  logic [31:0] isr_m = usart_rb_pkg::ISR_RESET_VALUE;
  logic [7:0]  rdr_m = '0;
  logic        irq_m = 1'b0;

  usart_register_block_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  function automatic usart_rb_pkg::usart_out_t predict_usart(usart_rb_pkg::usart_in_t w);
    usart_rb_pkg::usart_out_t r;
    logic                     in_window;
    r = '0;
    in_window = int'(w.reg_offset) < usart_rb_pkg::WINDOW_BYTES;
    case (w.cmd)
      usart_rb_pkg::CMD_READ: if (in_window) begin
        case (w.reg_offset)
          usart_rb_pkg::OFS_CR1:  r.read_data = cr1_m;
          usart_rb_pkg::OFS_CR2:  r.read_data = cr2_m;
          usart_rb_pkg::OFS_CR3:  r.read_data = cr3_m;
          usart_rb_pkg::OFS_BRR:  r.read_data = brr_m;
          usart_rb_pkg::OFS_GTPR: r.read_data = gtpr_m;
          usart_rb_pkg::OFS_RTOR: r.read_data = rtor_m;
          usart_rb_pkg::OFS_RQR:  r.read_data = rqr_m;
          usart_rb_pkg::OFS_ISR:  r.read_data = isr_m;
          usart_rb_pkg::OFS_ICR:  r.read_data = icr_m;
          usart_rb_pkg::OFS_RDR: begin
            r.read_data = {24'h0, rdr_m};
            isr_m[usart_rb_pkg::ISR_RXNE_BIT] = 1'b0;
            irq_m = 1'b0;
          end
          default: r.read_data = '0;
        endcase
      end
      usart_rb_pkg::CMD_WRITE: if (in_window) begin
        case (w.reg_offset)
          usart_rb_pkg::OFS_CR1: begin
            cr1_m = w.write_data;
            if (cr1_m[usart_rb_pkg::CR1_RXNEIE_BIT] && isr_m[usart_rb_pkg::ISR_RXNE_BIT])
              irq_m = 1'b1;
          end
          usart_rb_pkg::OFS_CR2:  cr2_m = w.write_data;
          usart_rb_pkg::OFS_CR3:  cr3_m = w.write_data;
          usart_rb_pkg::OFS_BRR:  brr_m = w.write_data;
          usart_rb_pkg::OFS_GTPR: gtpr_m = w.write_data;
          usart_rb_pkg::OFS_RTOR: rtor_m = w.write_data;
          usart_rb_pkg::OFS_RQR:  rqr_m = w.write_data;
          usart_rb_pkg::OFS_ISR: begin
            // small values replace the status with TXE held set, large ones mask it
            if (w.write_data <= usart_rb_pkg::ISR_REPLACE_MAX) begin
              isr_m = w.write_data;
              isr_m[usart_rb_pkg::ISR_TXE_BIT] = 1'b1;
            end else begin
              isr_m &= w.write_data;
            end
            if (!isr_m[usart_rb_pkg::ISR_RXNE_BIT]) irq_m = 1'b0;
          end
          usart_rb_pkg::OFS_ICR:  icr_m = w.write_data;
          usart_rb_pkg::OFS_TDR: if (w.write_data < usart_rb_pkg::TDR_LIMIT) begin
            r.tx_valid = 1'b1;
            r.tx_byte = w.write_data[7:0];
            isr_m[usart_rb_pkg::ISR_TC_BIT] = 1'b1;
          end
          default: ;
        endcase
      end
      usart_rb_pkg::CMD_RX: begin
        if (isr_m[usart_rb_pkg::ISR_RXNE_BIT]) begin
          r.rx_status = usart_rb_pkg::RX_REFUSED;
        end else if (!(cr1_m[usart_rb_pkg::CR1_UE_BIT] && cr1_m[usart_rb_pkg::CR1_RE_BIT])) begin
          r.rx_status = usart_rb_pkg::RX_DROPPED;
        end else begin
          rdr_m = w.rx_byte;
          isr_m[usart_rb_pkg::ISR_RXNE_BIT] = 1'b1;
          if (cr1_m[usart_rb_pkg::CR1_RXNEIE_BIT]) irq_m = 1'b1;
          r.rx_status = usart_rb_pkg::RX_ACCEPTED;
        end
      end
      default: ;
    endcase
    r.irq_level = irq_m;
    return r;
  endfunction

  function automatic logic [9:0] map_offset(int idx);
    case (idx)
      0: return usart_rb_pkg::OFS_CR1;
      1: return usart_rb_pkg::OFS_CR2;
      2: return usart_rb_pkg::OFS_CR3;
      3: return usart_rb_pkg::OFS_BRR;
      4: return usart_rb_pkg::OFS_GTPR;
      5: return usart_rb_pkg::OFS_RTOR;
      6: return usart_rb_pkg::OFS_RQR;
      7: return usart_rb_pkg::OFS_ISR;
      8: return usart_rb_pkg::OFS_ICR;
      9: return usart_rb_pkg::OFS_RDR;
      default: return usart_rb_pkg::OFS_TDR;
    endcase
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_word(usart_rb_pkg::cmd_t c, logic [9:0] ofs, logic [31:0] d,
                          logic [7:0] b, logic hold);
    pending_t p;
    p.word.cmd = c;
    p.word.reg_offset = ofs;
    p.word.write_data = d;
    p.word.rx_byte = b;
    p.hold = hold;
    pend_q.push_back(p);
  endtask

  task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch on %s: expected %h, got %h", field, want, got);
  endtask

  // sender: words from the pending queue, random gaps, hold-off on marked words
  int in_gap = 0, in_calm = 0, in_flight = 0;
  always @(posedge clk) begin
    int flight_now;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
      in_calm <= 0;
      in_flight <= 0;
    end else begin
      flight_now = in_flight + ((in_valid && in_ready) ? 1 : 0)
                   - ((out_valid && out_ready) ? 1 : 0);
      in_flight <= flight_now;
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pend_q.size() != 0 && !(pend_q[0].hold && flight_now != 0)) begin
          in_data <= pend_q[0].word;
          in_valid <= 1'b1;
          pend_q.pop_front();
          if (in_calm != 0) begin
            in_calm <= in_calm - 1;
          end else begin
            in_gap <= pick_gap();
            if ($urandom_range(0, 99) < 2) in_calm <= $urandom_range(40, 150);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, with calm stretches of constant ready
  int out_stall = 0, out_calm = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
      out_calm <= 0;
    end else if (out_stall != 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (out_calm != 0) begin
        if (out_valid && out_ready) out_calm <= out_calm - 1;
      end else if ((out_valid && out_ready) || $urandom_range(0, 15) == 0) begin
        out_stall <= pick_gap();
        if ($urandom_range(0, 99) < 2) out_calm <= $urandom_range(40, 150);
      end
    end
  end

  // check results against the oldest prediction, then predict for the accepted word
  always @(posedge clk) begin
    usart_rb_pkg::usart_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", out_data);
        end else begin
          want = expected_q.pop_front();
          if (out_data.read_data !== want.read_data)
            flag_field("read_data", want.read_data, out_data.read_data);
          if (out_data.irq_level !== want.irq_level)
            flag_field("irq_level", 32'(want.irq_level), 32'(out_data.irq_level));
          if (out_data.tx_valid !== want.tx_valid)
            flag_field("tx_valid", 32'(want.tx_valid), 32'(out_data.tx_valid));
          if (out_data.tx_byte !== want.tx_byte)
            flag_field("tx_byte", 32'(want.tx_byte), 32'(out_data.tx_byte));
          if (out_data.rx_status !== want.rx_status)
            flag_field("rx_status", 32'(want.rx_status), 32'(out_data.rx_status));
        end
      end
      if (in_valid && in_ready) expected_q.push_back(predict_usart(in_data));
    end
  end

  int quiet = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("FAIL usart_register_block_top");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    int          made;
    int          kind;
    logic [31:0] d;
    logic [31:0] ue_re;
    ue_re = (32'h1 << usart_rb_pkg::CR1_UE_BIT) | (32'h1 << usart_rb_pkg::CR1_RE_BIT);

    // directed: receive path, interrupt rules, status replace/mask, transmit limits
    add_word(usart_rb_pkg::CMD_READ,  usart_rb_pkg::OFS_ISR, '0, '0, 1'b0);
    add_word(usart_rb_pkg::CMD_READ,  usart_rb_pkg::OFS_CR1, '0, '0, 1'b0);
    add_word(usart_rb_pkg::CMD_RX,    usart_rb_pkg::OFS_CR1, '0, 8'h00, 1'b0);
    add_word(usart_rb_pkg::CMD_WRITE, usart_rb_pkg::OFS_CR1, 32'h25, '0, 1'b0);
    add_word(usart_rb_pkg::CMD_RX,    usart_rb_pkg::OFS_CR1, '0, 8'hFF, 1'b0);
    add_word(usart_rb_pkg::CMD_RX,    usart_rb_pkg::OFS_CR1, '0, 8'h00, 1'b0);
    add_word(usart_rb_pkg::CMD_READ,  usart_rb_pkg::OFS_ISR, '0, '0, 1'b0);
    add_word(usart_rb_pkg::CMD_READ,  usart_rb_pkg::OFS_RDR, '0, '0, 1'b0);
    add_word(usart_rb_pkg::CMD_WRITE, usart_rb_pkg::OFS_CR1, 32'h05, '0, 1'b0);
    add_word(usart_rb_pkg::CMD_RX,    usart_rb_pkg::OFS_CR1, '0, 8'hA5, 1'b0);
    add_word(usart_rb_pkg::CMD_WRITE, usart_rb_pkg::OFS_CR1, 32'h25, '0, 1'b0);
    add_word(usart_rb_pkg::CMD_WRITE, usart_rb_pkg::OFS_ISR, usart_rb_pkg::ISR_REPLACE_MAX,
             '0, 1'b0);
    add_word(usart_rb_pkg::CMD_WRITE, usart_rb_pkg::OFS_ISR, 32'h400, '0, 1'b0);
    add_word(usart_rb_pkg::CMD_WRITE, usart_rb_pkg::OFS_ISR, 32'h0, '0, 1'b0);
    add_word(usart_rb_pkg::CMD_WRITE, usart_rb_pkg::OFS_TDR, 32'hFF, '0, 1'b0);
    add_word(usart_rb_pkg::CMD_WRITE, usart_rb_pkg::OFS_TDR, usart_rb_pkg::TDR_LIMIT,
             '0, 1'b0);
    add_word(usart_rb_pkg::CMD_WRITE, usart_rb_pkg::OFS_TDR, 32'h0, '0, 1'b0);
    add_word(usart_rb_pkg::CMD_READ,  usart_rb_pkg::OFS_TDR, '0, '0, 1'b0);
    add_word(usart_rb_pkg::CMD_WRITE, usart_rb_pkg::OFS_CR2, 32'hFFFF_FFFF, '0, 1'b1);
    add_word(usart_rb_pkg::CMD_READ,  usart_rb_pkg::OFS_CR2, '0, '0, 1'b0);
    add_word(usart_rb_pkg::CMD_WRITE, 10'h001, 32'hFFFF_FFFF, '0, 1'b0);
    add_word(usart_rb_pkg::CMD_READ,  10'h3FF, '0, '0, 1'b0);
    add_word(usart_rb_pkg::CMD_WRITE, usart_rb_pkg::OFS_RDR, 32'h12, '0, 1'b0);
    add_word(usart_rb_pkg::CMD_NONE,  10'h3FF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    add_word(usart_rb_pkg::CMD_WRITE, usart_rb_pkg::OFS_ISR, 32'hFFFF_FFFF, '0, 1'b0);
    add_word(usart_rb_pkg::CMD_READ,  usart_rb_pkg::OFS_ISR, '0, '0, 1'b0);

    // random: mostly well-formed receive and transmit sequences, some noise
    made = 0;
    while (made < RANDOM_WORDS) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        if ($urandom_range(0, 2) == 0) begin
          d = $urandom;
          if ($urandom_range(0, 4) != 0) d |= ue_re;
          add_word(usart_rb_pkg::CMD_WRITE, usart_rb_pkg::OFS_CR1, d, 8'($urandom), 1'b0);
          made++;
        end
        add_word(usart_rb_pkg::CMD_RX, 10'($urandom), $urandom, 8'($urandom),
                 $urandom_range(0, 199) == 0);
        made++;
        if ($urandom_range(0, 3) == 0) begin
          add_word(usart_rb_pkg::CMD_RX, 10'($urandom), $urandom, 8'($urandom), 1'b0);
          made++;
        end
        if ($urandom_range(0, 1) == 0) begin
          add_word(usart_rb_pkg::CMD_READ, usart_rb_pkg::OFS_ISR, $urandom, 8'($urandom),
                   1'b0);
          made++;
        end
        if ($urandom_range(0, 4) != 0) begin
          add_word(usart_rb_pkg::CMD_READ, usart_rb_pkg::OFS_RDR, $urandom, 8'($urandom),
                   1'b0);
          made++;
        end
      end else if (kind < 50) begin
        d = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 255);
        add_word(usart_rb_pkg::CMD_WRITE, usart_rb_pkg::OFS_TDR, d, 8'($urandom),
                 $urandom_range(0, 199) == 0);
        add_word(usart_rb_pkg::CMD_READ, usart_rb_pkg::OFS_ISR, $urandom, 8'($urandom),
                 1'b0);
        made += 2;
      end else if (kind < 65) begin
        d = $urandom;
        kind = $urandom_range(0, 10);
        add_word(usart_rb_pkg::CMD_WRITE, map_offset(kind), d, 8'($urandom), 1'b0);
        add_word(usart_rb_pkg::CMD_READ, map_offset(kind), $urandom, 8'($urandom), 1'b0);
        made += 2;
      end else if (kind < 75) begin
        d = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 32'h3FF) : $urandom;
        add_word(usart_rb_pkg::CMD_WRITE, usart_rb_pkg::OFS_ISR, d, 8'($urandom), 1'b0);
        made++;
      end else if (kind < 85) begin
        // noise: any command at any offset
        add_word(usart_rb_pkg::cmd_t'($urandom_range(0, 3)), 10'($urandom), $urandom,
                 8'($urandom), 1'b0);
        made++;
      end else if (kind < 95) begin
        add_word(usart_rb_pkg::CMD_RX, 10'($urandom), $urandom, 8'($urandom), 1'b0);
        made++;
      end else begin
        add_word(usart_rb_pkg::CMD_WRITE, usart_rb_pkg::OFS_CR1, $urandom, 8'($urandom),
                 1'b0);
        made++;
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (pend_q.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("PASS usart_register_block_top");
    else
      $display("FAIL usart_register_block_top");
    $finish;
  end

endmodule
